/* hw/rtl/ncrp_pkg.sv */
// Shared types and constants for the NCHW to channel-blocked repack unit.
package ncrp_pkg;

  localparam int unsigned OffsetBits = 48;
  localparam int unsigned DimBits    = 11;
  localparam int unsigned DimCap     = 1 << DimBits;
  localparam int unsigned BatchBits  = 6;
  localparam int unsigned BatchCap   = 1 << BatchBits;
  localparam int unsigned LaneBits   = 4;
  localparam int unsigned BlkBits    = DimBits - 3;
  localparam int unsigned PlaneBits  = 2 * DimBits + 1;
  localparam int unsigned PbytesBits = PlaneBits + 2;
  localparam int unsigned StepBits   = PbytesBits + LaneBits;
  localparam int unsigned BbytesBits = PbytesBits + DimBits + 1;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = DimBits + 1;
  localparam int unsigned EszBits    = 3;
  localparam int unsigned EszMax     = 4;
  localparam int unsigned SettleCycles = 4;

  typedef logic [OffsetBits-1:0] offset_t;
  typedef logic [DimBits-1:0]    dim_t;
  typedef logic [DimBits:0]      cnt_t;
  typedef logic [BatchBits-1:0]  batch_t;
  typedef logic [BatchBits:0]    batch_cnt_t;
  typedef logic [LaneBits-1:0]   lane_t;
  typedef logic [BlkBits-1:0]    blk_t;
  typedef logic [EszBits-1:0]    esz_t;
  typedef logic [PlaneBits-1:0]  plane_t;
  typedef logic [PbytesBits-1:0] pbytes_t;
  typedef logic [StepBits-1:0]   step_t;
  typedef logic [BbytesBits-1:0] bbytes_t;
  typedef logic [CfgBits-1:0]    cfg_data_t;

  typedef enum logic [CfgIdxBits-1:0] {
    RegBatchCount   = 3'd0,
    RegChannelCount = 3'd1,
    RegRowCount     = 3'd2,
    RegColumnCount  = 3'd3,
    RegWideBlocks   = 3'd4,
    RegElementBytes = 3'd5
  } cfg_reg_e;

  function automatic cnt_t clamp_dim(cnt_t v);
    cnt_t r;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (v > cnt_t'(DimCap)) begin
      r = cnt_t'(DimCap);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/nchw_to_channel_blocked_repack_unit.sv */
// Address generator for an NCHW to NCHWc (8 or 16 lane) layout transform.
// Each accepted item yields one destination element, in destination order:
// batch, channel block, row, column, lane. Source offsets are tracked with adds only.
// Throughput is one item per clock unless the output stalls or the sizes settle; an accepted
// item's result is registered on the next clock. After reset and after every write to a
// defined register the input side holds ready low while the plane and batch byte sizes run
// through the size multipliers. Any write to a defined register restarts the walk.
module nchw_to_channel_blocked_repack_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ncrp_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  ncrp_pkg::cfg_data_t                cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ncrp_pkg::offset_t                  dst_offset_o,
  output ncrp_pkg::offset_t                  src_offset_o,
  output logic                               is_padding_o,
  output logic                               is_last_o
);

  // configuration registers
  ncrp_pkg::batch_cnt_t batch_cnt_q;
  ncrp_pkg::cnt_t       chan_cnt_q, row_cnt_q, col_cnt_q;
  logic                 wide_q;
  ncrp_pkg::esz_t       esz_raw_q;
  logic                 cfg_we;

  // derived sizes
  ncrp_pkg::cnt_t     c_eff_q, h_eff_q, w_eff_q;
  ncrp_pkg::esz_t     esz_q;
  ncrp_pkg::batch_t   n_last_q;
  ncrp_pkg::blk_t     blk_last_q;
  ncrp_pkg::dim_t     h_last_q, w_last_q;
  ncrp_pkg::plane_t   plane_q;
  ncrp_pkg::pbytes_t  pbytes_q;
  ncrp_pkg::step_t    block_step_q;
  ncrp_pkg::bbytes_t  bbytes_q;
  logic [2:0]         settle_q;

  ncrp_pkg::batch_cnt_t n_eff;
  ncrp_pkg::cnt_t       c_eff, h_eff, w_eff;
  ncrp_pkg::esz_t       esz_eff;
  logic [ncrp_pkg::DimBits+1:0] blocks;

  // walk state
  ncrp_pkg::batch_t  batch_q, batch_d, cur_batch;
  ncrp_pkg::blk_t    blk_q, blk_d, cur_blk;
  ncrp_pkg::dim_t    row_q, row_d, cur_row;
  ncrp_pkg::dim_t    col_q, col_d, cur_col;
  ncrp_pkg::lane_t   lane_q, lane_d, cur_lane;
  ncrp_pkg::offset_t dst_q, dst_d, cur_dst;
  ncrp_pkg::offset_t lane_src_q, lane_src_d, cur_lane_src;
  ncrp_pkg::offset_t pix_src_q, pix_src_d, cur_pix_src;
  ncrp_pkg::offset_t blk_src_q, blk_src_d, cur_blk_src;
  ncrp_pkg::offset_t base_q, base_d, cur_base;

  // result register
  logic              out_valid_q;
  ncrp_pkg::offset_t out_dst_q, out_src_q;
  logic              out_pad_q, out_last_q;

  logic                accept;
  ncrp_pkg::cnt_t      channel;
  ncrp_pkg::lane_t     lane_max;
  logic                pad, last;
  logic                lane_wrap, col_wrap, row_wrap, blk_wrap, bat_wrap;
  ncrp_pkg::offset_t   esz_off, pix_next, blk_next, base_next;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && (cfg_index_i <= ncrp_pkg::CfgIdxBits'(ncrp_pkg::RegElementBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_cnt_q <= ncrp_pkg::batch_cnt_t'(1);
      chan_cnt_q  <= ncrp_pkg::cnt_t'(8);
      row_cnt_q   <= ncrp_pkg::cnt_t'(1);
      col_cnt_q   <= ncrp_pkg::cnt_t'(1);
      wide_q      <= 1'b0;
      esz_raw_q   <= ncrp_pkg::esz_t'(2);
    end else if (cfg_valid_i) begin
      unique case (ncrp_pkg::cfg_reg_e'(cfg_index_i))
        ncrp_pkg::RegBatchCount:   batch_cnt_q <= cfg_data_i[ncrp_pkg::BatchBits:0];
        ncrp_pkg::RegChannelCount: chan_cnt_q  <= cfg_data_i;
        ncrp_pkg::RegRowCount:     row_cnt_q   <= cfg_data_i;
        ncrp_pkg::RegColumnCount:  col_cnt_q   <= cfg_data_i;
        ncrp_pkg::RegWideBlocks:   wide_q      <= cfg_data_i[0];
        ncrp_pkg::RegElementBytes: esz_raw_q   <= cfg_data_i[ncrp_pkg::EszBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (batch_cnt_q == '0) begin
      n_eff = ncrp_pkg::batch_cnt_t'(1);
    end else if (batch_cnt_q > ncrp_pkg::batch_cnt_t'(ncrp_pkg::BatchCap)) begin
      n_eff = ncrp_pkg::batch_cnt_t'(ncrp_pkg::BatchCap);
    end else begin
      n_eff = batch_cnt_q;
    end
    if (esz_raw_q == '0) begin
      esz_eff = ncrp_pkg::esz_t'(1);
    end else if (esz_raw_q > ncrp_pkg::esz_t'(ncrp_pkg::EszMax)) begin
      esz_eff = ncrp_pkg::esz_t'(ncrp_pkg::EszMax);
    end else begin
      esz_eff = esz_raw_q;
    end
    c_eff = ncrp_pkg::clamp_dim(chan_cnt_q);
    h_eff = ncrp_pkg::clamp_dim(row_cnt_q);
    w_eff = ncrp_pkg::clamp_dim(col_cnt_q);
    if (wide_q) begin
      blocks = ({1'b0, c_eff} + (ncrp_pkg::DimBits+2)'(15)) >> 4;
    end else begin
      blocks = ({1'b0, c_eff} + (ncrp_pkg::DimBits+2)'(7)) >> 3;
    end
  end

  // size pipeline: clamp, H*W, *esz, then block step and batch size
  always_ff @(posedge clk_i) begin
    c_eff_q    <= c_eff;
    h_eff_q    <= h_eff;
    w_eff_q    <= w_eff;
    esz_q      <= esz_eff;
    n_last_q   <= ncrp_pkg::batch_t'(n_eff - ncrp_pkg::batch_cnt_t'(1));
    h_last_q   <= ncrp_pkg::dim_t'(h_eff - ncrp_pkg::cnt_t'(1));
    w_last_q   <= ncrp_pkg::dim_t'(w_eff - ncrp_pkg::cnt_t'(1));
    blk_last_q <= ncrp_pkg::blk_t'(blocks - (ncrp_pkg::DimBits+2)'(1));
    plane_q    <= ncrp_pkg::plane_t'(h_eff_q * w_eff_q);
    pbytes_q   <= ncrp_pkg::pbytes_t'(plane_q * esz_q);
    bbytes_q   <= ncrp_pkg::bbytes_t'(c_eff_q * pbytes_q);
    if (wide_q) begin
      block_step_q <= ncrp_pkg::step_t'(pbytes_q) << 4;
    end else begin
      block_step_q <= ncrp_pkg::step_t'(pbytes_q) << 3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 3'(ncrp_pkg::SettleCycles);
    end else if (cfg_we) begin
      settle_q <= 3'(ncrp_pkg::SettleCycles);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  assign in_ready_o = (settle_q == '0) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (restart_i) begin
      cur_batch = '0; cur_blk = '0; cur_row = '0; cur_col = '0; cur_lane = '0;
      cur_dst = '0; cur_lane_src = '0; cur_pix_src = '0; cur_blk_src = '0; cur_base = '0;
    end else begin
      cur_batch = batch_q; cur_blk = blk_q; cur_row = row_q; cur_col = col_q;
      cur_lane = lane_q; cur_dst = dst_q; cur_lane_src = lane_src_q;
      cur_pix_src = pix_src_q; cur_blk_src = blk_src_q; cur_base = base_q;
    end

    lane_max = wide_q ? ncrp_pkg::lane_t'(15) : ncrp_pkg::lane_t'(7);
    channel  = wide_q ? {cur_blk, cur_lane} : {1'b0, cur_blk, cur_lane[2:0]};
    pad      = channel >= c_eff_q;

    lane_wrap = cur_lane == lane_max;
    col_wrap  = cur_col == w_last_q;
    row_wrap  = cur_row == h_last_q;
    blk_wrap  = cur_blk == blk_last_q;
    bat_wrap  = cur_batch == n_last_q;
    last      = lane_wrap && col_wrap && row_wrap && blk_wrap && bat_wrap;

    esz_off   = ncrp_pkg::offset_t'(esz_q);
    pix_next  = cur_pix_src + esz_off;
    blk_next  = cur_blk_src + ncrp_pkg::offset_t'(block_step_q);
    base_next = cur_base + ncrp_pkg::offset_t'(bbytes_q);

    batch_d = cur_batch; blk_d = cur_blk; row_d = cur_row; col_d = cur_col;
    lane_d = cur_lane; lane_src_d = cur_lane_src; pix_src_d = cur_pix_src;
    blk_src_d = cur_blk_src; base_d = cur_base;
    dst_d = cur_dst + esz_off;

    if (last) begin
      batch_d = '0; blk_d = '0; row_d = '0; col_d = '0; lane_d = '0;
      dst_d = '0; lane_src_d = '0; pix_src_d = '0; blk_src_d = '0; base_d = '0;
    end else if (!lane_wrap) begin
      lane_d     = cur_lane + ncrp_pkg::lane_t'(1);
      lane_src_d = cur_lane_src + ncrp_pkg::offset_t'(pbytes_q);
    end else begin
      lane_d = '0;
      if (!(col_wrap && row_wrap)) begin
        pix_src_d  = pix_next;
        lane_src_d = pix_next;
        if (!col_wrap) begin
          col_d = cur_col + ncrp_pkg::dim_t'(1);
        end else begin
          col_d = '0;
          row_d = cur_row + ncrp_pkg::dim_t'(1);
        end
      end else begin
        col_d = '0;
        row_d = '0;
        if (!blk_wrap) begin
          blk_d      = cur_blk + ncrp_pkg::blk_t'(1);
          blk_src_d  = blk_next;
          pix_src_d  = blk_next;
          lane_src_d = blk_next;
        end else begin
          blk_d      = '0;
          batch_d    = cur_batch + ncrp_pkg::batch_t'(1);
          base_d     = base_next;
          blk_src_d  = base_next;
          pix_src_d  = base_next;
          lane_src_d = base_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= '0; blk_q <= '0; row_q <= '0; col_q <= '0; lane_q <= '0;
      dst_q <= '0; lane_src_q <= '0; pix_src_q <= '0; blk_src_q <= '0; base_q <= '0;
    end else if (cfg_we) begin
      batch_q <= '0; blk_q <= '0; row_q <= '0; col_q <= '0; lane_q <= '0;
      dst_q <= '0; lane_src_q <= '0; pix_src_q <= '0; blk_src_q <= '0; base_q <= '0;
    end else if (accept) begin
      batch_q <= batch_d; blk_q <= blk_d; row_q <= row_d; col_q <= col_d;
      lane_q <= lane_d; dst_q <= dst_d; lane_src_q <= lane_src_d;
      pix_src_q <= pix_src_d; blk_src_q <= blk_src_d; base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_dst_q  <= cur_dst;
      out_src_q  <= pad ? '0 : cur_lane_src;
      out_pad_q  <= pad;
      out_last_q <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dst_offset_o = out_dst_q;
  assign src_offset_o = out_src_q;
  assign is_padding_o = out_pad_q;
  assign is_last_o    = out_last_q;

`ifndef ASSERT_OFF
  a_pad_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_padding_o |-> src_offset_o == '0)
    else $error("padding item with nonzero source offset");

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last_q && col_q <= w_last_q && blk_q <= blk_last_q && lane_q <= lane_max)
    else $error("walk index beyond tensor bounds");

  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> !in_ready_o)
    else $error("input accepted while sizes settle after a configuration write");
`endif

endmodule

/* tb/nchw_to_channel_blocked_repack_unit_tb.sv */
// Self-checking testbench for the NCHW to channel-blocked repack address generator.
module nchw_to_channel_blocked_repack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncrp_pkg::*;

  localparam logic [CfgIdxBits-1:0] UnusedRegA = 3'd6;
  localparam logic [CfgIdxBits-1:0] UnusedRegB = 3'd7;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    offset_t dst;
    offset_t src;
    logic    pad;
    logic    last;
  } elem_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CfgIdxBits-1:0] idx;
    cfg_data_t             data;
    logic                  rs;
    logic                  typed;
    elem_t                 exp;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  cfg_data_t             cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  offset_t               dst_offset_o;
  offset_t               src_offset_o;
  logic                  is_padding_o;
  logic                  is_last_o;

  nchw_to_channel_blocked_repack_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dst_offset_o (dst_offset_o),
    .src_offset_o (src_offset_o),
    .is_padding_o (is_padding_o),
    .is_last_o    (is_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies, reset values
  logic [6:0]  cfg_batches = 7'd1;
  logic [11:0] cfg_chans   = 12'd8;
  logic [11:0] cfg_rows    = 12'd1;
  logic [11:0] cfg_cols    = 12'd1;
  logic        cfg_wide    = 1'b0;
  logic [2:0]  cfg_esz     = 3'd2;

  // Walk position
  batch_t  batch_idx = '0;
  blk_t    blk_idx   = '0;
  dim_t    row_idx   = '0;
  dim_t    col_idx   = '0;
  lane_t   lane_idx  = '0;
  offset_t dst_cur   = '0;
  plane_t  pix_cur   = '0;
  offset_t batch_off = '0;

  elem_t pending_elems[$];
  plan_row_t plan_rows[$];
  int unsigned feed_idle_pct = 11;
  int unsigned sink_idle_pct = 69;
  logic  typed_pending = 1'b0;
  elem_t typed_elem = '0;

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned lasts_seen = 0;
  int unsigned pads_seen = 0;
  int unsigned restarts_sent = 0;
  int unsigned reg_writes = 0;

  function automatic int unsigned bound_count(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void note_expected(elem_t e);
    pending_elems = {pending_elems, e};
  endfunction

  function automatic void plan_add(plan_row_t r);
    plan_rows = {plan_rows, r};
  endfunction

  task automatic walk_home();
    batch_idx = '0;
    blk_idx   = '0;
    row_idx   = '0;
    col_idx   = '0;
    lane_idx  = '0;
    dst_cur   = '0;
    pix_cur   = '0;
    batch_off = '0;
  endtask

  task automatic advance_walk(input logic rs, output elem_t e);
    int unsigned n_cnt, c_cnt, h_cnt, w_cnt, esz, lanes, blocks;
    longint unsigned plane, chan, src_full;
    logic last_flag;
    n_cnt  = bound_count(cfg_batches, BatchCap);
    c_cnt  = bound_count(cfg_chans, DimCap);
    h_cnt  = bound_count(cfg_rows, DimCap);
    w_cnt  = bound_count(cfg_cols, DimCap);
    esz    = bound_count(cfg_esz, EszMax);
    lanes  = cfg_wide ? 16 : 8;
    blocks = (c_cnt + lanes - 1) / lanes;
    plane  = longint'(h_cnt) * w_cnt;
    if (rs) walk_home();
    chan = longint'(blk_idx) * lanes + lane_idx;
    last_flag = (batch_idx + 1 == n_cnt) && (blk_idx + 1 == blocks) &&
                (row_idx + 1 == h_cnt) && (col_idx + 1 == w_cnt) &&
                (lane_idx + 1 == lanes);
    e.dst  = dst_cur;
    e.pad  = (chan >= c_cnt);
    e.last = last_flag;
    src_full = longint'(batch_off) + (chan * plane + pix_cur) * esz;
    e.src = e.pad ? '0 : offset_t'(src_full);
    if (last_flag) begin
      walk_home();
    end else begin
      dst_cur = dst_cur + offset_t'(esz);
      if (lane_idx + 1 < lanes) begin
        lane_idx = lane_idx + 1'b1;
      end else begin
        lane_idx = '0;
        pix_cur  = pix_cur + 1'b1;
        if (col_idx + 1 < w_cnt) begin
          col_idx = col_idx + 1'b1;
        end else begin
          col_idx = '0;
          if (row_idx + 1 < h_cnt) begin
            row_idx = row_idx + 1'b1;
          end else begin
            row_idx = '0;
            pix_cur = '0;
            if (blk_idx + 1 < blocks) begin
              blk_idx = blk_idx + 1'b1;
            end else begin
              blk_idx   = '0;
              batch_off = batch_off + offset_t'(longint'(c_cnt) * plane * esz);
              if (batch_idx + 1 >= n_cnt) begin
                walk_home();
              end else begin
                batch_idx = batch_idx + 1'b1;
              end
            end
          end
        end
      end
    end
  endtask

  // Sampling at the rising edge: results, then register writes and items
  always @(posedge clk_i) begin
    elem_t got, want, pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{dst: dst_offset_o, src: src_offset_o, pad: is_padding_o, last: is_last_o};
        results_seen++;
        if (is_last_o === 1'b1) lasts_seen++;
        if (is_padding_o === 1'b1) pads_seen++;
        if (pending_elems.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxShown) begin
            $display("[%0t] unexpected result: dst=%h src=%h pad=%b last=%b",
                     $realtime, got.dst, got.src, got.pad, got.last);
          end
        end else begin
          want = pending_elems.pop_front();
          if (got.dst !== want.dst || got.src !== want.src ||
              got.pad !== want.pad || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= MaxShown) begin
              $display("[%0t] mismatch: exp dst=%h src=%h pad=%b last=%b",
                       $realtime, want.dst, want.src, want.pad, want.last);
              $display("              got dst=%h src=%h pad=%b last=%b",
                       got.dst, got.src, got.pad, got.last);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          RegBatchCount:   begin cfg_batches = cfg_data_i[6:0]; walk_home(); end
          RegChannelCount: begin cfg_chans = cfg_data_i[11:0]; walk_home(); end
          RegRowCount:     begin cfg_rows = cfg_data_i[11:0]; walk_home(); end
          RegColumnCount:  begin cfg_cols = cfg_data_i[11:0]; walk_home(); end
          RegWideBlocks:   begin cfg_wide = cfg_data_i[0]; walk_home(); end
          RegElementBytes: begin cfg_esz = cfg_data_i[2:0]; walk_home(); end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        items_sent++;
        if (restart_i) restarts_sent++;
        advance_walk(restart_i, pred);
        note_expected(typed_pending ? typed_elem : pred);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_elems.size() != 0) @(negedge clk_i);
    repeat (SettleCycles + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, cfg_data_t val);
    wait_drained();
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_item(logic rs, logic typed, elem_t exp);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    restart_i     = rs;
    typed_pending = typed;
    typed_elem    = exp;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic plan_row_t item_row(logic rs);
    plan_row_t r;
    r = '0;
    r.rs = rs;
    return r;
  endfunction

  function automatic plan_row_t check_row(logic rs, offset_t d, offset_t s, logic p, logic l);
    plan_row_t r;
    r = '0;
    r.rs = rs;
    r.typed = 1'b1;
    r.exp = '{dst: d, src: s, pad: p, last: l};
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxBits-1:0] idx, cfg_data_t v);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = v;
    return r;
  endfunction

  task automatic pick_config();
    cfg_data_t v;
    logic big;
    for (int i = 0; i < 6; i++) begin
      big = ($urandom_range(9) == 0);
      case (cfg_reg_e'(i))
        RegBatchCount:   v = cfg_data_t'(big ? $urandom_range(127) : $urandom_range(2));
        RegChannelCount: v = cfg_data_t'(big ? $urandom_range(4095) : $urandom_range(20));
        RegRowCount:     v = cfg_data_t'(big ? $urandom_range(4095) : $urandom_range(3));
        RegColumnCount:  v = cfg_data_t'(big ? $urandom_range(4095) : $urandom_range(3));
        RegWideBlocks:   v = cfg_data_t'($urandom_range(1));
        default:         v = cfg_data_t'($urandom_range(7));
      endcase
      write_reg(cfg_reg_e'(i), v);
    end
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? UnusedRegA : UnusedRegB,
                cfg_data_t'($urandom_range(4095)));
    end
  endtask

  initial begin
    plan_row_t row;
    int unsigned guard;
    // after reset: N=1 C=8 H=1 W=1, 8 lanes, 2 bytes
    plan_add(check_row(1'b0, 48'd0, 48'd0, 1'b0, 1'b0));
    plan_add(check_row(1'b0, 48'd2, 48'd2, 1'b0, 1'b0));
    plan_add(check_row(1'b1, 48'd0, 48'd0, 1'b0, 1'b0));
    repeat (6) plan_add(item_row(1'b0));
    plan_add(check_row(1'b0, 48'd14, 48'd14, 1'b0, 1'b1));
    plan_add(check_row(1'b0, 48'd0, 48'd0, 1'b0, 1'b0));
    // one real channel: lanes past it are padding
    plan_add(reg_row(RegChannelCount, 12'd1));
    plan_add(check_row(1'b0, 48'd0, 48'd0, 1'b0, 1'b0));
    plan_add(check_row(1'b0, 48'd2, 48'd0, 1'b1, 1'b0));
    // zero counts and odd element sizes
    plan_add(reg_row(RegChannelCount, 12'd0));
    plan_add(reg_row(RegWideBlocks, 12'd1));
    plan_add(reg_row(RegElementBytes, 12'd0));
    plan_add(item_row(1'b0));
    plan_add(item_row(1'b0));
    plan_add(reg_row(RegElementBytes, 12'd3));
    plan_add(item_row(1'b0));
    plan_add(reg_row(RegElementBytes, 12'd7));
    plan_add(item_row(1'b0));
    // undefined index: no restart
    plan_add(reg_row(UnusedRegA, 12'hFFF));
    plan_add(item_row(1'b0));
    // oversized dimensions
    plan_add(reg_row(RegBatchCount, 12'd127));
    plan_add(reg_row(RegChannelCount, 12'hFFF));
    plan_add(reg_row(RegRowCount, 12'hFFF));
    plan_add(reg_row(RegColumnCount, 12'hFFF));
    plan_add(reg_row(RegWideBlocks, 12'd0));
    plan_add(reg_row(RegElementBytes, 12'd4));
    plan_add(item_row(1'b0));
    plan_add(item_row(1'b0));
    plan_add(item_row(1'b1));
    plan_add(reg_row(RegBatchCount, 12'd64));
    plan_add(reg_row(RegChannelCount, 12'd2048));
    plan_add(reg_row(RegRowCount, 12'd2048));
    plan_add(reg_row(RegColumnCount, 12'd2048));
    plan_add(item_row(1'b0));
    plan_add(item_row(1'b0));
    plan_add(reg_row(RegBatchCount, 12'd0));
    plan_add(reg_row(RegRowCount, 12'd0));
    plan_add(reg_row(RegColumnCount, 12'd0));
    plan_add(reg_row(RegChannelCount, 12'd9));
    plan_add(reg_row(RegElementBytes, 12'd5));
    plan_add(reg_row(UnusedRegB, 12'd0));
    plan_add(item_row(1'b0));
    plan_add(item_row(1'b0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan_rows[i]) begin
      row = plan_rows[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.data);
      end else begin
        push_item(row.rs, row.typed, row.exp);
      end
    end
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      feed_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 69 : 0;
      sink_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 11 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        pick_config();
        for (int k = 0; k < 47; k++) begin
          push_item($urandom_range(99) < 3, 1'b0, '0);
          if (ph == 0 && seg == 3 && k == 23) wait_drained();
        end
      end
    end

    in_valid_i = 1'b0;
    guard = 0;
    while (pending_elems.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SettleCycles + 4) @(negedge clk_i);
    fail_count += pending_elems.size();

    $display("covered %0d items (%0d restarts), %0d register writes, %0d results checked",
             items_sent, restarts_sent, reg_writes, results_seen);
    $display("walk ends seen: %0d, padding lanes seen: %0d, failures: %0d",
             lasts_seen, pads_seen, fail_count);
    if (fail_count == 0) begin
      $display("** nchw_to_channel_blocked_repack_unit: PASSED **");
    end else begin
      $display("** nchw_to_channel_blocked_repack_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still expected", pending_elems.size());
    $display("** nchw_to_channel_blocked_repack_unit: FAILED **");
    $finish;
  end

endmodule
